// ===== sv/rstk_pkg.sv =====
// ----------------------------------------------------------------------------
// rstk_pkg
// shared widths, codes and constants for the resizing stack tracker
// ----------------------------------------------------------------------------
package rstk_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int VAL_W      = 32;
    localparam int CAP_W      = 11;
    localparam int ITEM_W     = 11;
    localparam int RSZ_W      = 32;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_MAX      = '1;
    localparam logic [CAP_W-1:0] BASE_MIN     = CAP_W'(2);
    localparam logic [CAP_W-1:0] BASE_RESET   = CAP_W'(10);
    localparam logic [VAL_W-1:0] EMPTY_VALUE  = VAL_W'(-99);
    localparam logic [RSZ_W-1:0] RSZ_MAX      = '1;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_REJECTED = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    typedef logic [DATA_WIDTH-1:0] t_data;

endpackage

// ===== sv/resizing_stack_tracker_top.sv =====
// ----------------------------------------------------------------------------
// resizing_stack_tracker_top
// lifo stack in a single-port memory with logical capacity tracking
// ----------------------------------------------------------------------------
// One transaction per cycle sustained while the output is not stalled. An
// accepted transaction is registered in the read stage, which also holds the
// registered memory read, and then moves into the output register. While the
// output is stalled the block holds one result there and one more in the read
// stage, then drops input ready. Push writes the memory, pop and peek read
// it, at most one access per transaction, so no two accesses meet in the same
// cycle. Capacity grows by 7/4 (saturating at CAP_MAX) when the count reaches
// it and halves (floor at base) when the count is at or below half; a pop
// tests the count from before it. Writing the base reloads capacity and peak
// and clears the resize count while keeping the stored entries.
module resizing_stack_tracker_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rstk_pkg::CAP_W-1:0]           i_base_capacity,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic signed [rstk_pkg::VAL_W-1:0]    i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rstk_pkg::VAL_W-1:0]    o_read_value,
    output logic [1:0]                           o_status,
    output logic [rstk_pkg::ITEM_W-1:0]          o_item_count,
    output logic [rstk_pkg::CAP_W-1:0]           o_logical_capacity,
    output logic [rstk_pkg::RSZ_W-1:0]           o_resize_count,
    output logic [rstk_pkg::CAP_W-1:0]           o_peak_capacity,
    output logic                                 o_is_empty,
    output logic                                 o_is_full
);
    import rstk_pkg::*;

    t_data                mem [DEPTH];
    t_data                r_rdata;

    logic [CAP_W-1:0]     r_base;
    logic [CNT_W-1:0]     r_count;
    logic [CAP_W-1:0]     r_cap;
    logic [CAP_W-1:0]     r_peak;
    logic [RSZ_W-1:0]     r_resizes;

    logic [CNT_W-1:0]     n_count;
    logic [CAP_W-1:0]     n_cap;
    logic [CAP_W-1:0]     n_peak;
    logic [RSZ_W-1:0]     n_resizes;

    logic                 r_p1_valid;
    logic                 r_p1_use_mem;
    logic [VAL_W-1:0]     r_p1_const;
    t_status              r_p1_status;
    logic [CNT_W-1:0]     r_p1_count;
    logic [CAP_W-1:0]     r_p1_cap;
    logic [CAP_W-1:0]     r_p1_peak;
    logic [RSZ_W-1:0]     r_p1_resizes;

    logic                 r_out_valid;

    logic                 in_fire;
    logic                 p1_adv;
    t_cmd                 cmd;
    logic                 is_empty_now;
    logic                 is_full_store;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;
    logic [CNT_W-1:0]     top_idx;
    logic                 do_check;
    logic [CNT_W-1:0]     chk_n;
    logic [CAP_W-1:0]     base_used;
    logic [CAP_W+2:0]     grown_full;
    logic [CAP_W-1:0]     grown;
    logic [CAP_W-1:0]     half;
    logic                 use_mem;
    logic [VAL_W-1:0]     rd_const;
    t_status              status;
    logic [CAP_W-1:0]     cfg_base_used;

    assign cmd           = t_cmd'(i_cmd);
    assign p1_adv        = r_p1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready    = !r_p1_valid || p1_adv;
    assign o_cfg_ready   = 1'b1;
    assign in_fire       = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;

    assign is_empty_now  = (r_count == '0);
    assign is_full_store = (r_count == CNT_W'(DEPTH));
    assign top_idx       = r_count - 1'b1;
    assign base_used     = (r_base < BASE_MIN) ? BASE_MIN : r_base;
    assign cfg_base_used = (i_base_capacity < BASE_MIN) ? BASE_MIN : i_base_capacity;
    assign grown_full    = ((CAP_W+3)'(r_cap) * (CAP_W+3)'(7)) >> 2;
    assign grown         = (grown_full > (CAP_W+3)'(CAP_MAX)) ? CAP_MAX : grown_full[CAP_W-1:0];
    assign half          = r_cap >> 1;

    always_comb begin
        n_count  = r_count;
        do_check = 1'b0;
        chk_n    = r_count;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = top_idx[ADDR_W-1:0];
        use_mem  = 1'b0;
        rd_const = '0;
        status   = ST_OK;
        unique case (cmd)
            CMD_PUSH: begin
                if (is_full_store) begin
                    status = ST_REJECTED;
                end else begin
                    mem_we   = in_fire;
                    mem_addr = r_count[ADDR_W-1:0];
                    n_count  = r_count + 1'b1;
                    chk_n    = n_count;
                    do_check = 1'b1;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (is_empty_now) begin
                    status   = ST_EMPTY;
                    rd_const = EMPTY_VALUE;
                end else begin
                    mem_re  = in_fire;
                    use_mem = 1'b1;
                    if (cmd == CMD_POP) begin
                        do_check = 1'b1;
                        n_count  = top_idx;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_cap     = r_cap;
        n_peak    = r_peak;
        n_resizes = r_resizes;
        if (do_check) begin
            if (CMP_W'(chk_n) >= CMP_W'(r_cap)) begin
                n_cap     = grown;
                n_peak    = (r_peak < grown) ? grown : r_peak;
                n_resizes = (r_resizes == RSZ_MAX) ? r_resizes : r_resizes + 1'b1;
            end else if (CMP_W'(chk_n) <= CMP_W'(half) && r_cap > base_used) begin
                n_cap     = (half < base_used) ? base_used : half;
                n_resizes = (r_resizes == RSZ_MAX) ? r_resizes : r_resizes + 1'b1;
            end
        end
    end

    // stack memory, single port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= DATA_WIDTH'(i_push_value);
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_count     <= '0;
            r_cap       <= BASE_RESET;
            r_peak      <= BASE_RESET;
            r_resizes   <= '0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                r_base    <= i_base_capacity;
                r_cap     <= cfg_base_used;
                r_peak    <= cfg_base_used;
                r_resizes <= '0;
            end else if (in_fire) begin
                r_cap     <= n_cap;
                r_peak    <= n_peak;
                r_resizes <= n_resizes;
            end
            if (in_fire) begin
                r_p1_valid <= 1'b1;
            end else if (p1_adv) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_p1_use_mem <= use_mem;
            r_p1_const   <= rd_const;
            r_p1_status  <= status;
            r_p1_count   <= n_count;
            r_p1_cap     <= n_cap;
            r_p1_peak    <= n_peak;
            r_p1_resizes <= n_resizes;
        end
        if (p1_adv) begin
            o_read_value       <= r_p1_use_mem ? VAL_W'(signed'(r_rdata)) : r_p1_const;
            o_status           <= r_p1_status;
            o_item_count       <= ITEM_W'(r_p1_count);
            o_logical_capacity <= r_p1_cap;
            o_resize_count     <= r_p1_resizes;
            o_peak_capacity    <= r_p1_peak;
            o_is_empty         <= (r_p1_count == '0);
            o_is_full          <= (r_p1_count != '0) && (CMP_W'(r_p1_count) >= CMP_W'(r_p1_cap));
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above store depth");

    a_cap_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap >= base_used)
        else $error("capacity below base");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_cap)
        else $error("peak capacity below capacity");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && cmd == CMD_PUSH && !is_full_store |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not advance count");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the resizing stack tracker. Directed and random push, pop, peek and
// no-op transactions run against a cycle-free model of the stack, with several
// base capacity settings. Both sides idle and stall at random, and one long
// receiver hold-off fills the block and stalls its input. Every result is
// compared field by field, in order, with the predicted one.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rstk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_OPS   = 20;
    localparam int DRAIN_OPS   = 30;

    typedef struct {
        logic [VAL_W-1:0]  read_value;
        t_status           status;
        logic [ITEM_W-1:0] item_count;
        logic [CAP_W-1:0]  logical_capacity;
        logic [RSZ_W-1:0]  resize_count;
        logic [CAP_W-1:0]  peak_capacity;
        logic              is_empty;
        logic              is_full;
    } t_stack_result;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CAP_W-1:0]        base_cap;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              cmd_drv;
    logic signed [VAL_W-1:0] push_value;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [ITEM_W-1:0]       item_count;
    logic [CAP_W-1:0]        logical_capacity;
    logic [RSZ_W-1:0]        resize_count;
    logic [CAP_W-1:0]        peak_capacity;
    logic                    is_empty;
    logic                    is_full;

    // model state
    t_data            stack_mem [DEPTH];
    int unsigned      held;
    int unsigned      base_reg;
    int unsigned      cap_now;
    int unsigned      cap_peak;
    logic [RSZ_W-1:0] resize_total;

    t_stack_result pending_stack_results [$];

    bit idle_on = 1'b1;
    int hold_left = 0;
    int err_count = 0;
    int ops_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int rejects_predicted = 0;

    resizing_stack_tracker_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_base_capacity    (base_cap),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_cmd              (cmd_drv),
        .i_push_value       (push_value),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_read_value       (read_value),
        .o_status           (status),
        .o_item_count       (item_count),
        .o_logical_capacity (logical_capacity),
        .o_resize_count     (resize_count),
        .o_peak_capacity    (peak_capacity),
        .o_is_empty         (is_empty),
        .o_is_full          (is_full)
    );

    initial clk = 1'b0;
    always begin
        #4ns clk = 1'b1;
        #4ns clk = 1'b0;
    end

    function automatic int unsigned base_floor();
        return (base_reg < BASE_MIN) ? int'(BASE_MIN) : base_reg;
    endfunction

    function automatic void apply_resize_policy();
        int unsigned grown;
        int unsigned half;
        if (held >= cap_now) begin
            grown = (cap_now * 7) >> 2;
            if (grown > CAP_MAX) grown = CAP_MAX;
            cap_now = grown;
            if (cap_peak < grown) cap_peak = grown;
            if (resize_total != RSZ_MAX) resize_total++;
        end else if (held <= cap_now / 2 && cap_now > base_floor()) begin
            half = cap_now / 2;
            cap_now = (half < base_floor()) ? base_floor() : half;
            if (resize_total != RSZ_MAX) resize_total++;
        end
    endfunction

    function automatic t_stack_result predict_stack_op(input t_cmd op,
                                                       input logic [VAL_W-1:0] value);
        t_stack_result r;
        r.read_value = '0;
        r.status     = ST_OK;
        case (op)
            CMD_PUSH: begin
                if (held >= DEPTH) begin
                    r.status = ST_REJECTED;
                    rejects_predicted++;
                end else begin
                    stack_mem[held] = t_data'(value);
                    held++;
                    apply_resize_policy();
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (held == 0) begin
                    r.read_value = EMPTY_VALUE;
                    r.status     = ST_EMPTY;
                end else begin
                    if (op == CMD_POP) apply_resize_policy();
                    r.read_value = VAL_W'($signed(stack_mem[held - 1]));
                    if (op == CMD_POP) held--;
                end
            end
            default: begin
            end
        endcase
        r.item_count       = ITEM_W'(held);
        r.logical_capacity = CAP_W'(cap_now);
        r.resize_count     = resize_total;
        r.peak_capacity    = CAP_W'(cap_peak);
        r.is_empty         = (held == 0);
        r.is_full          = (held != 0 && held >= cap_now);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] random_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // starts and ends just after a falling edge
    task automatic send_op(input t_cmd op, input logic [VAL_W-1:0] value);
        while (idle_on && $urandom_range(0, 99) < 24) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd_drv    <= op;
        push_value <= value;
        do @(posedge clk); while (!in_ready);
        pending_stack_results.push_back(predict_stack_op(op, value));
        ops_sent++;
        @(negedge clk);
    endtask

    task automatic write_base(input logic [CAP_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_stack_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        base_cap  <= value;
        do @(posedge clk); while (!cfg_ready);
        base_reg     = value;
        cap_now      = base_floor();
        cap_peak     = cap_now;
        resize_total = '0;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // pop, peek and no-op on an empty stack at the reset base
    task automatic test_empty_access();
        send_op(CMD_POP, 32'h1234_5678);
        send_op(CMD_PEEK, 32'hffff_ffff);
        send_op(CMD_NOP, 32'h8000_0000);
    endtask

    task automatic test_value_extremes();
        send_op(CMD_PUSH, 32'h7fff_ffff);
        send_op(CMD_PUSH, 32'h8000_0000);
        send_op(CMD_PEEK, 32'h0);
        send_op(CMD_NOP, 32'h7fff_ffff);
        send_op(CMD_POP, 32'h0);
        send_op(CMD_POP, 32'h0);
    endtask

    // base below range, grow on push and shrink on pop
    task automatic test_grow_and_shrink();
        write_base(CAP_W'(1));
        send_op(CMD_PUSH, 32'h0);
        send_op(CMD_PUSH, 32'hffff_ffff);
        send_op(CMD_PUSH, 32'h5555_5555);
        send_op(CMD_PUSH, 32'haaaa_aaaa);
        send_op(CMD_PEEK, 32'h0);
        repeat (4) send_op(CMD_POP, 32'h0);
        send_op(CMD_POP, 32'h0);
    endtask

    task automatic test_random_traffic();
        int unsigned bases [6] = '{2, 2047, 0, 1024, 10, 0};
        int unsigned seg_len;
        int unsigned push_pct;
        int unsigned roll;
        int          sent;
        t_cmd        op;
        for (int p = 0; p < 6; p++) begin
            write_base(p == 5 ? CAP_W'($urandom_range(3, 40)) : CAP_W'(bases[p]));
            idle_on = (p != 4);
            sent = 0;
            while (sent < PHASE_OPS) begin
                seg_len  = $urandom_range(5, 15);
                push_pct = $urandom_range(0, 1) ? 75 : 30;
                repeat (seg_len) begin
                    if (sent < PHASE_OPS) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 4) op = CMD_NOP;
                        else if (roll < 16) op = CMD_PEEK;
                        else if ($urandom_range(0, 99) < push_pct) op = CMD_PUSH;
                        else op = CMD_POP;
                        send_op(op, random_word());
                        sent++;
                    end
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // long receiver hold-off while the store fills up, a stretch with no
    // idling, then a base write with every entry held and a partial drain
    task automatic test_store_full();
        int unsigned n;
        hold_left = 300;
        n = DEPTH + 3 - held;
        for (int unsigned i = 0; i < n; i++) begin
            idle_on = (i < 200) || (i >= 400);
            send_op(CMD_PUSH, random_word());
        end
        idle_on = 1'b1;
        write_base(CAP_W'(2));
        send_op(CMD_PUSH, random_word());
        repeat (DRAIN_OPS)
            send_op($urandom_range(0, 7) == 0 ? CMD_PEEK : CMD_POP, random_word());
        send_op(CMD_PEEK, random_word());
        write_base(CAP_W'(1024));
        send_op(CMD_PUSH, random_word());
        send_op(CMD_POP, random_word());
    endtask

    // receiver side
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= !(idle_on && $urandom_range(0, 99) < 24);
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_stack_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_stack_results.size() == 0) begin
                $error("result transaction with no expected result waiting");
                err_count++;
            end else begin
                want = pending_stack_results.pop_front();
                check_field("read_value", want.read_value, read_value);
                check_field("status", 32'(want.status), 32'(status));
                check_field("item_count", 32'(want.item_count), 32'(item_count));
                check_field("logical_capacity", 32'(want.logical_capacity),
                            32'(logical_capacity));
                check_field("resize_count", want.resize_count, resize_count);
                check_field("peak_capacity", 32'(want.peak_capacity), 32'(peak_capacity));
                check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
                check_field("is_full", 32'(want.is_full), 32'(is_full));
                results_checked++;
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        base_cap     = BASE_RESET;
        in_valid     = 1'b0;
        cmd_drv      = CMD_PUSH;
        push_value   = '0;
        base_reg     = BASE_RESET;
        held         = 0;
        cap_now      = base_floor();
        cap_peak     = cap_now;
        resize_total = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_access();
        test_value_extremes();
        test_grow_and_shrink();
        test_random_traffic();
        test_store_full();

        in_valid <= 1'b0;
        while (pending_stack_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("stack transactions sent %0d, results checked %0d", ops_sent,
                 results_checked);
        $display("base settings written %0d, pushes rejected on a full store %0d",
                 settings_used, rejects_predicted);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/rstk_pkg.sv
sv/resizing_stack_tracker_top.sv
verif/tb.sv
